FILE: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

FILE: rtl/core/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic ORDER_MIN_FIRST = 1'b0;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: rtl/core/spq_cell.sv
// One storage cell of the sorted chain: compare, insert, shift.
module spq_cell import spq_pkg::*; #(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    order_mode,
  input  logic [KEY_BITS-1:0]     cmp_key,
  input  cell_ctl_t               ctl,
  input  logic                    occupied,
  input  logic                    hit_in,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    hit_out
);

  logic beats;
  logic hit;

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= (order_mode == ORDER_MIN_FIRST) ? (cmp_key < key) : (cmp_key > key);
    end
  end

  assign hit     = occupied ? beats : 1'b1;
  assign hit_out = hit_in | hit;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      key     <= right_key;
      payload <= right_payload;
    end else if (ctl.push) begin
      if (hit_in) begin
        key     <= left_key;
        payload <= left_payload;
      end else if (hit) begin
        key     <= new_key;
        payload <= new_payload;
      end
    end
  end

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, count, config port, cell chain.
//
// channel   direction  beat taken when                  fields
// command   in         start & !busy                    func, key, payload
// result    out        done (one cycle, no stall)       pop_valid, out_key, out_payload,
//                                                       entry_count, status
// config    in         psel & penable & pwrite          paddr, pwdata (order_mode at 0)
//
// The cells compare the key at the accept edge,
// then the chain inserts or shifts and the result register loads at the next edge.
// done rises in the cycle after that edge; busy is low again in the same cycle.
// A new command is not accepted while busy is high.
// rst is synchronous: count, order_mode and the control state clear; cell contents do not.
// The receiver cannot stall; each result shows for exactly one cycle.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic [KEY_BITS-1:0]     key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    done,
  output logic                    pop_valid,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [CNT_W-1:0]        entry_count,
  output status_t                 status,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  localparam logic REG_ORDER_MODE = 1'b0;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic                    state;
  logic                    order_mode;
  logic [CNT_W-1:0]        count;
  logic                    op_func;
  logic [KEY_BITS-1:0]     op_key;
  logic [PAYLOAD_BITS-1:0] op_payload;
  logic                    accept;
  logic                    full;
  logic                    empty;
  cell_ctl_t               ctl;

  logic [KEY_BITS-1:0]     cell_key     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
  logic                    hit_chain    [CAPACITY];

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_APPLY);
  assign full   = (count == CNT_FULL);
  assign empty  = (count == '0);

  assign ctl.push = (state == ST_APPLY) && (op_func == FUNC_PUSH) && !full;
  assign ctl.pop  = (state == ST_APPLY) && (op_func == FUNC_POP) && !empty;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ORDER_MODE) ? {31'b0, order_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= ORDER_MIN_FIRST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORDER_MODE)) begin
      order_mode <= pwdata[0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= (state == ST_APPLY);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state <= ST_IDLE;
          if (ctl.push) begin
            count <= count + 1'b1;
          end else if (ctl.pop) begin
            count <= count - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func    <= func;
      op_key     <= key;
      op_payload <= payload;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      pop_valid   <= 1'b0;
      out_key     <= '0;
      out_payload <= '0;
      status      <= STATUS_OK;
      entry_count <= count;
      if (op_func == FUNC_POP) begin
        if (empty) begin
          status <= STATUS_EMPTY;
        end else begin
          pop_valid   <= 1'b1;
          out_key     <= cell_key[0];
          out_payload <= cell_payload[0];
          entry_count <= count - 1'b1;
        end
      end else begin
        if (full) begin
          status <= STATUS_FULL;
        end else begin
          entry_count <= count + 1'b1;
        end
      end
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    logic                    hit_in;
    logic [KEY_BITS-1:0]     left_key;
    logic [PAYLOAD_BITS-1:0] left_payload;
    logic [KEY_BITS-1:0]     right_key;
    logic [PAYLOAD_BITS-1:0] right_payload;

    if (i == 0) begin : g_head
      assign hit_in       = 1'b0;
      assign left_key     = cell_key[0];
      assign left_payload = cell_payload[0];
    end else begin : g_body
      assign hit_in       = hit_chain[i-1];
      assign left_key     = cell_key[i-1];
      assign left_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key     = cell_key[i];
      assign right_payload = cell_payload[i];
    end else begin : g_mid
      assign right_key     = cell_key[i+1];
      assign right_payload = cell_payload[i+1];
    end

    spq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .load          (accept),
      .order_mode    (order_mode),
      .cmp_key       (key),
      .ctl           (ctl),
      .occupied      (IDX < count),
      .hit_in        (hit_in),
      .new_key       (op_key),
      .new_payload   (op_payload),
      .left_key      (left_key),
      .left_payload  (left_payload),
      .right_key     (right_key),
      .right_payload (right_payload),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .hit_out       (hit_chain[i])
    );
  end

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             pop_valid,
  input logic [CNT_W-1:0] entry_count,
  input status_t          status
);

  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SPQ_ASSERT_NOW(a_accept_done, start && !busy, ##2 done)
  `SPQ_ASSERT_NOW(a_pop_ok, done && pop_valid, status == STATUS_OK)
  `SPQ_ASSERT_NOW(a_full_count, done && (status == STATUS_FULL), entry_count == CNT_W'(CAPACITY))
  `SPQ_ASSERT_NOW(a_empty_count, done && (status == STATUS_EMPTY), entry_count == '0)

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pop_valid   (pop_valid),
  .entry_count (entry_count),
  .status      (status)
);
